// ===== src/tlsrd_pkg.sv =====
`timescale 1ns / 1ps

package tlsrd_pkg;

    // Record content types.
    localparam logic [7:0] CT_CCS         = 8'd20;
    localparam logic [7:0] CT_ALERT       = 8'd21;
    localparam logic [7:0] CT_HANDSHAKE   = 8'd22;
    localparam logic [7:0] CT_APPLICATION = 8'd23;

    // Bytes that open a plain-text HTTP request.
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_P = 8'h50;

    // Status codes carried with every result.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_HTTP     = 2'd2;
    localparam logic [1:0] ST_HALTED   = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] peer_minor;
        logic [7:0] peer_major;
        logic       record_last;
        logic [1:0] route;
        logic       payload_valid;
        logic [7:0] payload_byte;
    } result_t;

    // Expected byte at position pos of the tail after 'G' ("ET ") or 'P' ("OST").
    function automatic logic [7:0] sniff_char(input logic is_get, input logic [1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (pos)
            2'd0: c = is_get ? 8'h45 : 8'h4F;
            2'd1: c = is_get ? 8'h54 : 8'h53;
            2'd2: c = is_get ? 8'h20 : 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/tlsrd_parser.sv =====
`timescale 1ns / 1ps

module tlsrd_parser import tlsrd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] data_byte,
    output result_t    res
);

    localparam logic [3:0] PH_TYPE      = 4'd0;
    localparam logic [3:0] PH_VER_MAJOR = 4'd1;
    localparam logic [3:0] PH_VER_MINOR = 4'd2;
    localparam logic [3:0] PH_LEN_HIGH  = 4'd3;
    localparam logic [3:0] PH_LEN_LOW   = 4'd4;
    localparam logic [3:0] PH_PAYLOAD   = 4'd5;
    localparam logic [3:0] PH_SNIFF0    = 4'd6;
    localparam logic [3:0] PH_SNIFF1    = 4'd7;
    localparam logic [3:0] PH_SNIFF2    = 4'd8;
    localparam logic [3:0] PH_HALT      = 4'd9;

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  record_type_reg, record_type_next;
    logic [7:0]  ver_major_reg, ver_major_next;
    logic [7:0]  ver_minor_reg, ver_minor_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        first_seen_reg, first_seen_next;
    logic        sniff_match_reg, sniff_match_next;

    logic [1:0]  route_now;
    logic        is_get;
    logic        tail_hit;
    logic [1:0]  sniff_pos;
    logic [15:0] length_now;

    assign route_now  = 2'(record_type_reg - CT_CCS);
    assign is_get     = (record_type_reg == CHAR_G);
    assign sniff_pos  = 2'(phase_reg - PH_SNIFF0);
    assign tail_hit   = (data_byte == sniff_char(is_get, sniff_pos));
    assign length_now = {length_high_reg, data_byte};

    always_comb begin
        phase_next       = phase_reg;
        record_type_next = record_type_reg;
        ver_major_next   = ver_major_reg;
        ver_minor_next   = ver_minor_reg;
        length_high_next = length_high_reg;
        bytes_left_next  = bytes_left_reg;
        first_seen_next  = first_seen_reg;
        sniff_match_next = sniff_match_reg;
        res              = '0;

        unique case (phase_reg)
            PH_TYPE: begin
                record_type_next = data_byte;
                if (data_byte >= CT_CCS && data_byte <= CT_APPLICATION) begin
                    first_seen_next = 1'b1;
                    phase_next      = PH_VER_MAJOR;
                end else if (!first_seen_reg && (data_byte == CHAR_G || data_byte == CHAR_P)) begin
                    sniff_match_next = 1'b1;
                    phase_next       = PH_SNIFF0;
                end else begin
                    res.status = ST_BAD_TYPE;
                    phase_next = PH_HALT;
                end
            end
            PH_SNIFF0, PH_SNIFF1: begin
                if (!tail_hit) begin
                    sniff_match_next = 1'b0;
                end
                phase_next = 4'(phase_reg + 4'd1);
            end
            PH_SNIFF2: begin
                sniff_match_next = sniff_match_reg && tail_hit;
                res.status       = (sniff_match_reg && tail_hit) ? ST_HTTP : ST_BAD_TYPE;
                phase_next       = PH_HALT;
            end
            PH_VER_MAJOR: begin
                ver_major_next = data_byte;
                phase_next     = PH_VER_MINOR;
            end
            PH_VER_MINOR: begin
                ver_minor_next = data_byte;
                phase_next     = PH_LEN_HIGH;
            end
            PH_LEN_HIGH: begin
                length_high_next = data_byte;
                phase_next       = PH_LEN_LOW;
            end
            PH_LEN_LOW: begin
                bytes_left_next = length_now;
                if (length_now == 16'd0) begin
                    res.route       = route_now;
                    res.record_last = 1'b1;
                    res.peer_major  = ver_major_reg;
                    res.peer_minor  = ver_minor_reg;
                    phase_next      = PH_TYPE;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                res.payload_byte  = data_byte;
                res.payload_valid = 1'b1;
                res.route         = route_now;
                bytes_left_next   = bytes_left_reg - 16'd1;
                if (bytes_left_reg == 16'd1) begin
                    res.record_last = 1'b1;
                    res.peer_major  = ver_major_reg;
                    res.peer_minor  = ver_minor_reg;
                    phase_next      = PH_TYPE;
                end
            end
            default: begin
                // Halted, and any unused code behaves the same way.
                res.status = ST_HALTED;
                phase_next = PH_HALT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_TYPE;
            record_type_reg <= 8'd0;
            ver_major_reg   <= 8'd0;
            ver_minor_reg   <= 8'd0;
            length_high_reg <= 8'd0;
            bytes_left_reg  <= 16'd0;
            first_seen_reg  <= 1'b0;
            sniff_match_reg <= 1'b1;
        end else if (advance) begin
            phase_reg       <= phase_next;
            record_type_reg <= record_type_next;
            ver_major_reg   <= ver_major_next;
            ver_minor_reg   <= ver_minor_next;
            length_high_reg <= length_high_next;
            bytes_left_reg  <= bytes_left_next;
            first_seen_reg  <= first_seen_next;
            sniff_match_reg <= sniff_match_next;
        end
    end

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.status != ST_OK) |=> (phase_reg == PH_HALT))
        else $error("error status did not halt the parser");

    a_last_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.record_last) |=> (phase_reg == PH_TYPE))
        else $error("record end did not return to the type byte");

    a_empty_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg == PH_LEN_LOW && length_high_reg == 8'd0
         && data_byte == 8'd0) |-> res.record_last)
        else $error("zero-length record not closed on its length byte");

endmodule

// ===== src/tlsrd_out_skid.sv =====
`timescale 1ns / 1ps

module tlsrd_out_skid import tlsrd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_fire) begin
                out_data_reg <= in_data;
            end
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("request accepted during stall was not parked");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry did not move to the output register");

endmodule

// ===== src/tls_record_deframer_top.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Payload
// ---------+-----------+-------------------------------------------------------
// s_       | in        | tdata[7:0] data_byte
// m_       | out       | tdata: payload_byte, peer_major, peer_minor;
//          |           | tuser: payload_valid, route, status; tlast: record_last
//
// Each accepted input request yields exactly one result request, registered in the
// output stage and shown in the following cycle at the earliest; while s_tready is
// high a new byte can be taken every cycle, as parser phase registers update per byte.
// A two-entry output stage (result register plus skid entry) keeps accepting
// while a result waits; s_tready drops only when both are full.
// aresetn (synchronous, active low) rearms the parser and empties the output stage.

module tls_record_deframer_top import tlsrd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream, one byte per request.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    // Result stream, one request per input byte.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [15:8] peer_major, [23:16] peer_minor
    output logic [4:0]  m_tuser,   // [0] payload_valid, [2:1] route, [4:3] status
    output logic        m_tlast    // record_last
);

    result_t parse_res;
    result_t out_res;
    logic    s_fire;

    assign s_fire = s_tvalid && s_tready;

    // Header parsing, payload tagging and HTTP sniffing on each accepted byte.
    tlsrd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s_fire),
        .data_byte (s_tdata),
        .res       (parse_res)
    );

    // Registered result with a skid entry so that a stall on the result side
    // does not stop the input side at once.
    tlsrd_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (parse_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.peer_minor, out_res.peer_major, out_res.payload_byte};
    assign m_tuser = {out_res.status, out_res.route, out_res.payload_valid};
    assign m_tlast = out_res.record_last;

endmodule
